FILE: hdl/uer_pkg.sv
// Shared types, constants and register codes for the echo ranger.
package uer_pkg;

  // Field and counter widths
  localparam int ELAPSED_W   = 20;
  localparam int PULSE_W     = 16;
  localparam int DIST_W      = 15;
  localparam int TRIG_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int OUTCOME_W   = 3;

  // Saturation limits and scaling
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [PULSE_W-1:0]   PULSE_MAX   = '1;
  localparam int                   DIST_MAX    = 32767;
  localparam int                   US_PER_CM   = 58;
  localparam int                   RECIP_EXTRA = 6;   // ceil(log2(US_PER_CM))
  localparam int                   DEFAULT_FRACTION_BITS = 4;

  // Register reset values
  localparam logic [ELAPSED_W-1:0] RST_SAMPLE_PERIOD = 20'd50000;
  localparam logic [ELAPSED_W-1:0] RST_ECHO_TIMEOUT  = 20'd35000;
  localparam logic [PULSE_W-1:0]   RST_MIN_WIDTH     = 16'd100;
  localparam logic [PULSE_W-1:0]   RST_MAX_WIDTH     = 16'd30000;
  localparam logic [TRIG_W-1:0]    RST_TRIGGER_WIDTH = 8'd10;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_TIMEOUT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH = 3'd4;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_NONE    = 3'd0,
    OUTCOME_VALID   = 3'd1,
    OUTCOME_RANGE   = 3'd2,
    OUTCOME_NO_RISE = 3'd3,
    OUTCOME_TIMEOUT = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] sample_period_us;
    logic [ELAPSED_W-1:0] echo_timeout_us;
    logic [PULSE_W-1:0]   min_width_us;
    logic [PULSE_W-1:0]   max_width_us;
    logic [TRIG_W-1:0]    trigger_width_us;
  } cfg_t;

  // One tick's result before distance scaling
  typedef struct packed {
    logic               trigger;
    outcome_t           outcome;
    logic               load;    // new valid width to convert
    logic               ok;      // held distance is valid
    logic [PULSE_W-1:0] width;
  } rec_t;

endpackage

FILE: hdl/uer_if.sv
// Channel interfaces: configuration writes, echo ticks and results.
interface uer_cfg_if import uer_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, echo_level, input ready);
  modport sink (input valid, echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 trigger_level;
  logic [DIST_W-1:0]    distance_q4;
  logic                 distance_ok;
  logic [OUTCOME_W-1:0] outcome;
  modport source (output valid, trigger_level, distance_q4, distance_ok, outcome,
                  input ready);
  modport sink (input valid, trigger_level, distance_q4, distance_ok, outcome,
                output ready);
endinterface

FILE: hdl/uer_cfg_regs.sv
// Configuration register file, written through the configuration channel.
module uer_cfg_regs import uer_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  uer_cfg_if.sink   cfg,
  output cfg_t      values
);

  assign cfg.ready = 1'b1;

  // Register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      values.sample_period_us <= RST_SAMPLE_PERIOD;
      values.echo_timeout_us  <= RST_ECHO_TIMEOUT;
      values.min_width_us     <= RST_MIN_WIDTH;
      values.max_width_us     <= RST_MAX_WIDTH;
      values.trigger_width_us <= RST_TRIGGER_WIDTH;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SAMPLE_PERIOD: values.sample_period_us <= cfg.data;
        CFG_ECHO_TIMEOUT:  values.echo_timeout_us  <= cfg.data;
        CFG_MIN_WIDTH:     values.min_width_us     <= cfg.data[PULSE_W-1:0];
        CFG_MAX_WIDTH:     values.max_width_us     <= cfg.data[PULSE_W-1:0];
        CFG_TRIGGER_WIDTH: values.trigger_width_us <= cfg.data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/uer_sequencer.sv
// Per-tick measurement sequencer: start, trigger, echo edge timing, timeout.
module uer_sequencer import uer_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    values,
  uer_in_if.sink  samples,
  output rec_t    rec,
  output logic    rec_valid,
  input  logic    rec_ready
);

  logic [ELAPSED_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic                 waiting_echo, waiting_echo_next;
  logic                 previous_echo;
  logic                 rise_seen, rise_seen_next;
  logic [PULSE_W-1:0]   pulse_ticks, pulse_ticks_next;
  logic                 held_valid, held_valid_next;
  rec_t                 rec_next;
  logic                 accept;
  logic                 start;
  logic [ELAPSED_W-1:0] el;

  assign samples.ready = !rec_valid || rec_ready;
  assign accept        = samples.valid && samples.ready;

  // Next state for one tick
  always_comb begin
    start              = !waiting_echo && (elapsed_ticks >= values.sample_period_us);
    el                 = start ? '0 : elapsed_ticks;
    waiting_echo_next  = waiting_echo || start;
    rise_seen_next     = start ? 1'b0 : rise_seen;
    pulse_ticks_next   = start ? '0 : pulse_ticks;
    held_valid_next    = held_valid;
    rec_next           = '0;
    rec_next.outcome   = OUTCOME_NONE;

    if (waiting_echo_next) begin
      rec_next.trigger = el < ELAPSED_W'(values.trigger_width_us);
      if (samples.echo_level && !previous_echo) begin
        // rise only counts once the trigger is low
        if (!rec_next.trigger) begin
          rise_seen_next   = 1'b1;
          pulse_ticks_next = PULSE_W'(1);
        end
      end else if (samples.echo_level) begin
        if (rise_seen_next && pulse_ticks_next != PULSE_MAX) begin
          pulse_ticks_next = pulse_ticks_next + 1'b1;
        end
      end else if (previous_echo) begin
        // falling edge ends the measurement
        if (!rise_seen_next) begin
          rec_next.outcome = OUTCOME_NO_RISE;
        end else if (pulse_ticks_next > values.min_width_us &&
                     pulse_ticks_next < values.max_width_us) begin
          rec_next.outcome = OUTCOME_VALID;
        end else begin
          rec_next.outcome = OUTCOME_RANGE;
        end
        held_valid_next   = (rec_next.outcome == OUTCOME_VALID);
        waiting_echo_next = 1'b0;
      end
      if (waiting_echo_next && el > values.echo_timeout_us) begin
        rec_next.outcome  = OUTCOME_TIMEOUT;
        held_valid_next   = 1'b0;
        waiting_echo_next = 1'b0;
      end
    end

    elapsed_ticks_next = (el == ELAPSED_MAX) ? el : el + 1'b1;
    rec_next.load      = (rec_next.outcome == OUTCOME_VALID);
    rec_next.ok        = held_valid_next;
    rec_next.width     = pulse_ticks_next;
  end

  // Measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= '0;
      waiting_echo  <= 1'b0;
      previous_echo <= 1'b0;
      rise_seen     <= 1'b0;
      pulse_ticks   <= '0;
      held_valid    <= 1'b0;
    end else if (accept) begin
      elapsed_ticks <= elapsed_ticks_next;
      waiting_echo  <= waiting_echo_next;
      previous_echo <= samples.echo_level;
      rise_seen     <= rise_seen_next;
      pulse_ticks   <= pulse_ticks_next;
      held_valid    <= held_valid_next;
    end
  end

  // Result register toward the scaler
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (accept) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec <= rec_next;
    end
  end

  a_pulse_needs_rise: assert property (@(posedge clk) disable iff (rst)
    (pulse_ticks != '0) |-> rise_seen)
    else $error("pulse count running without a rise");

  a_end_clears_wait: assert property (@(posedge clk) disable iff (rst)
    (accept && rec_next.outcome != OUTCOME_NONE) |=> !waiting_echo)
    else $error("measurement still open after an outcome");

  a_load_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec.load) |-> (rec.ok && rec.outcome == OUTCOME_VALID))
    else $error("valid width without valid flag");

endmodule

FILE: hdl/uer_scaler.sv
// Width to distance scaling by reciprocal multiply, and the held output register.
module uer_scaler import uer_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  rec_t       rec,
  input  logic       rec_valid,
  output logic       rec_ready,
  uer_out_if.source  results
);

  // floor(x / 58) == (x * MULT) >> KSH for every x below 2**XW
  localparam int XW  = PULSE_W + FRACTION_BITS;
  localparam int KSH = XW + RECIP_EXTRA;
  localparam int MW  = KSH - 5;
  localparam int PW  = XW + MW;
  localparam int QW  = PW - KSH;
  localparam longint unsigned MULT =
    ((64'd1 << KSH) + longint'(US_PER_CM) - 64'd1) / longint'(US_PER_CM);

  logic              v2;
  logic              trig2;
  outcome_t          outcome2;
  logic              ok2;
  logic              load2;
  logic [PW-1:0]     prod2;
  logic [XW-1:0]     scaled;
  logic [QW-1:0]     quot;
  logic [DIST_W-1:0] dist_next;
  logic              out_free;
  logic              move12;
  logic              move23;

  assign out_free  = !results.valid || results.ready;
  assign rec_ready = !v2 || out_free;
  assign move12    = rec_valid && rec_ready;
  assign move23    = v2 && out_free;

  // Multiply stage
  assign scaled = XW'(rec.width) << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move12) begin
      v2 <= 1'b1;
    end else if (out_free) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move12) begin
      trig2    <= rec.trigger;
      outcome2 <= rec.outcome;
      ok2      <= rec.ok;
      load2    <= rec.load;
      prod2    <= PW'(scaled) * PW'(MW'(MULT));
    end
  end

  // Quotient with saturation; otherwise hold the last distance
  always_comb begin
    quot = prod2[PW-1:KSH];
    if (!load2) begin
      dist_next = results.distance_q4;
    end else if (32'(quot) > 32'(DIST_MAX)) begin
      dist_next = DIST_W'(DIST_MAX);
    end else begin
      dist_next = DIST_W'(quot);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid       <= 1'b0;
      results.distance_q4 <= '0;
    end else begin
      if (move23) begin
        results.valid       <= 1'b1;
        results.distance_q4 <= dist_next;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move23) begin
      results.trigger_level <= trig2;
      results.distance_ok   <= ok2;
      results.outcome       <= outcome2;
    end
  end

  a_hold_distance: assert property (@(posedge clk) disable iff (rst)
    !(move23 && load2) |=> $stable(results.distance_q4))
    else $error("held distance changed without a valid measurement");

endmodule

FILE: hdl/ultrasonic_echo_ranger_core.sv
// Path: a tick's result passes the sequencer register, the multiplier register and
// the output register before it is valid.
// Throughput: one tick per cycle while no stage is stalled; the measurement state updates per accepted tick.
// Backpressure stalls stages one by one; empty stages still take new ticks.
// Reset (rst, synchronous): counters and flags clear, registers take defaults,
// the held distance reads zero.
module ultrasonic_echo_ranger_core import uer_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic       clk,
  input  logic       rst,
  uer_cfg_if.sink    cfg,
  uer_in_if.sink     samples,
  uer_out_if.source  results
);

  cfg_t  cfg_values;
  rec_t  rec;
  logic  rec_valid;
  logic  rec_ready;

  uer_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .values (cfg_values)
  );

  uer_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .values    (cfg_values),
    .samples   (samples),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready)
  );

  uer_scaler #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scaler (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .results   (results)
  );

endmodule

FILE: verif/ultrasonic_echo_ranger_core_tb.sv
// Self-checking testbench for the echo ranger core: each reading vs. a per-tick predictor.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core_tb;
  import uer_pkg::*;

  localparam int FRACTION_BITS = DEFAULT_FRACTION_BITS;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_TICKS   = 160;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int TIMEOUT_NS    = 20_000_000;

  // One expected reading per echo tick
  typedef struct packed {
    logic              trigger;
    logic [DIST_W-1:0] distance;
    logic              ok;
    outcome_t          outcome;
  } reading_t;

  logic clk;
  logic rst;

  uer_cfg_if cfg_bus();
  uer_in_if  tick_bus();
  uer_out_if reading_bus();

  ultrasonic_echo_ranger_core #(.FRACTION_BITS(FRACTION_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .samples(tick_bus),
    .results(reading_bus)
  );

  // Predictor state and register copy
  cfg_t                 ranger_regs;
  logic [ELAPSED_W-1:0] tick_elapsed;
  bit                   in_measurement;
  bit                   last_echo;
  bit                   rise_found;
  logic [PULSE_W-1:0]   pulse_count;
  logic [DIST_W-1:0]    held_dist;
  bit                   held_ok;

  reading_t pending_readings[$];
  int       error_count;
  int       ticks_sent;
  int       readings_checked;
  int       outcome_seen [0:4];
  bit       idle_on;
  bit       hold_arm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the ranger by one tick and return the reading it produces
  function automatic reading_t predict_tick(input logic echo);
    reading_t        r;
    logic            trig;
    outcome_t        oc;
    longint unsigned q;
    trig = 1'b0;
    oc = OUTCOME_NONE;
    if (!in_measurement && tick_elapsed >= ranger_regs.sample_period_us) begin
      tick_elapsed = '0;
      in_measurement = 1'b1;
      rise_found = 1'b0;
      pulse_count = '0;
    end
    if (in_measurement) begin
      trig = tick_elapsed < ranger_regs.trigger_width_us;
      if (echo && !last_echo) begin
        // rises under the trigger are crosstalk, not echo
        if (!trig) begin
          rise_found = 1'b1;
          pulse_count = PULSE_W'(1);
        end
      end else if (echo) begin
        if (rise_found && pulse_count != PULSE_MAX) pulse_count = pulse_count + 1'b1;
      end else if (last_echo) begin
        if (!rise_found) begin
          oc = OUTCOME_NO_RISE;
        end else if (pulse_count > ranger_regs.min_width_us &&
                     pulse_count < ranger_regs.max_width_us) begin
          oc = OUTCOME_VALID;
          q = (longint'(pulse_count) << FRACTION_BITS) / US_PER_CM;
          held_dist = (q > DIST_MAX) ? DIST_W'(DIST_MAX) : q[DIST_W-1:0];
        end else begin
          oc = OUTCOME_RANGE;
        end
        held_ok = (oc == OUTCOME_VALID);
        in_measurement = 1'b0;
      end
      // a fall on the same tick takes priority over the timeout
      if (in_measurement && tick_elapsed > ranger_regs.echo_timeout_us) begin
        oc = OUTCOME_TIMEOUT;
        held_ok = 1'b0;
        in_measurement = 1'b0;
      end
    end
    last_echo = echo;
    if (tick_elapsed != ELAPSED_MAX) tick_elapsed = tick_elapsed + 1'b1;
    r.trigger = trig;
    r.distance = held_dist;
    r.ok = held_ok;
    r.outcome = oc;
    return r;
  endfunction

  // One echo tick transfer, then its expected reading
  task automatic send_tick(input logic echo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.echo_level <= echo;
    do @(posedge clk); while (!tick_bus.ready);
    pending_readings.push_back(predict_tick(echo));
    ticks_sent++;
  endtask

  task automatic drain_readings();
    tick_bus.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Registers change only once the block has gone quiet
  task automatic set_config(input cfg_t regs);
    drain_readings();
    write_reg(CFG_SAMPLE_PERIOD, regs.sample_period_us);
    write_reg(CFG_ECHO_TIMEOUT, regs.echo_timeout_us);
    write_reg(CFG_MIN_WIDTH, CFG_DATA_W'(regs.min_width_us));
    write_reg(CFG_MAX_WIDTH, CFG_DATA_W'(regs.max_width_us));
    write_reg(CFG_TRIGGER_WIDTH, CFG_DATA_W'(regs.trigger_width_us));
    cfg_bus.valid <= 1'b0;
    ranger_regs = regs;
  endtask

  // Low ticks until the trigger is done, then an echo pulse of the given width
  task automatic run_pulse(input int high_ticks);
    int guard;
    guard = int'(ranger_regs.sample_period_us) + int'(ranger_regs.trigger_width_us) + 2;
    while (!(in_measurement && tick_elapsed >= ranger_regs.trigger_width_us) && guard > 0) begin
      send_tick(1'b0);
      guard--;
    end
    if (high_ticks > 0) begin
      repeat (high_ticks) send_tick(1'b1);
      send_tick(1'b0);
    end
  endtask

  // Default registers: period far off, so ticks stay idle
  task automatic test_reset_defaults();
    repeat (4) send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_directed_cases();
    set_config('{sample_period_us: 20'd0, echo_timeout_us: 20'd4, min_width_us: 16'd1,
                 max_width_us: 16'd4, trigger_width_us: 8'd1});
    run_pulse(2);          // valid width
    run_pulse(1);          // not above the minimum
    run_pulse(4);          // at the maximum, fall lands with the timeout
    run_pulse(6);          // still high at timeout; late fall has no rise
    repeat (7) send_tick(1'b0);  // no echo at all
    // rise under the trigger does not count
    set_config('{sample_period_us: 20'd0, echo_timeout_us: 20'd8, min_width_us: 16'd0,
                 max_width_us: 16'd16, trigger_width_us: 8'd3});
    run_pulse(2);
    repeat (5) send_tick(1'b1);
    send_tick(1'b0);
    // zero trigger width and zero timeout
    set_config('{sample_period_us: 20'd0, echo_timeout_us: 20'd0, min_width_us: 16'd0,
                 max_width_us: 16'd4, trigger_width_us: 8'd0});
    run_pulse(1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Reader holds off while ticks keep coming, so the input stalls
  task automatic test_output_stall();
    set_config('{sample_period_us: 20'd12, echo_timeout_us: 20'd40, min_width_us: 16'd2,
                 max_width_us: 16'd30, trigger_width_us: 8'd3});
    idle_on <= 1'b0;
    hold_arm <= ~hold_arm;
    repeat (4) run_pulse($urandom_range(1, 20));
    idle_on <= 1'b1;
  endtask

  // Register extremes: longest trigger, widest limits, swapped limits, no start
  task automatic test_register_extremes();
    set_config('{sample_period_us: 20'd0, echo_timeout_us: ELAPSED_MAX, min_width_us: 16'd0,
                 max_width_us: PULSE_MAX, trigger_width_us: 8'd255});
    idle_on <= 1'b0;
    run_pulse(40);
    // min not below max: nothing is ever valid
    set_config('{sample_period_us: 20'd0, echo_timeout_us: 20'd20, min_width_us: PULSE_MAX,
                 max_width_us: 16'd0, trigger_width_us: 8'd1});
    run_pulse(5);
    set_config('{sample_period_us: ELAPSED_MAX, echo_timeout_us: 20'd0, min_width_us: 16'd0,
                 max_width_us: 16'd0, trigger_width_us: 8'd1});
    repeat (6) send_tick(1'($urandom_range(0, 1)));
    idle_on <= 1'b1;
  endtask

  // Mostly well-formed pulses of random width, some noise bursts
  task automatic test_random_traffic();
    cfg_t regs;
    int   phase_start;
    int   width;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      regs.sample_period_us = ELAPSED_W'($urandom_range(0, 60));
      regs.echo_timeout_us = ELAPSED_W'($urandom_range(0, 70));
      regs.min_width_us = PULSE_W'($urandom_range(0, 10));
      regs.max_width_us = PULSE_W'($urandom_range(0, 24));
      regs.trigger_width_us = TRIG_W'($urandom_range(0, 8));
      set_config(regs);
      idle_on <= (phase % 2 == 0);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 3) == 0) width = $urandom_range(0, 3);
          else width = $urandom_range(1, int'(regs.max_width_us) + 4);
          run_pulse(width);
        end else begin
          repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
        end
      end
    end
    idle_on <= 1'b1;
  endtask

  // Reading side: random stalls, plus one long hold-off on request
  initial begin : reading_sink
    int gap_left;
    int hold_left;
    bit hold_seen;
    gap_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    reading_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_arm != hold_seen) begin
        hold_seen = hold_arm;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        reading_bus.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        reading_bus.ready <= 1'b0;
        gap_left--;
      end else begin
        reading_bus.ready <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Each reading transfer against the oldest expectation
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && reading_bus.valid && reading_bus.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ns: reading with nothing expected, actual outcome %0d", $time,
                 reading_bus.outcome);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        report_field("trigger_level", 32'(want.trigger), 32'(reading_bus.trigger_level));
        report_field("distance_q4", 32'(want.distance), 32'(reading_bus.distance_q4));
        report_field("distance_ok", 32'(want.ok), 32'(reading_bus.distance_ok));
        report_field("outcome", 32'(want.outcome), 32'(reading_bus.outcome));
        readings_checked++;
      end
      if (reading_bus.outcome <= OUTCOME_TIMEOUT) outcome_seen[reading_bus.outcome]++;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_SAMPLE_PERIOD;
    cfg_bus.data <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.echo_level <= 1'b0;
    idle_on <= 1'b1;
    ranger_regs = '{sample_period_us: RST_SAMPLE_PERIOD, echo_timeout_us: RST_ECHO_TIMEOUT,
                    min_width_us: RST_MIN_WIDTH, max_width_us: RST_MAX_WIDTH,
                    trigger_width_us: RST_TRIGGER_WIDTH};
    tick_elapsed = '0;
    in_measurement = 1'b0;
    last_echo = 1'b0;
    rise_found = 1'b0;
    pulse_count = '0;
    held_dist = '0;
    held_ok = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_output_stall();
    test_register_extremes();
    test_random_traffic();
    drain_readings();

    $display("Ran %0d echo ticks (directed, stall, extremes, random); %0d readings checked.",
             ticks_sent, readings_checked);
    $display("Outcomes: none %0d, valid %0d, out of range %0d, no rise %0d, timeout %0d.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
